### hdl/port_label_hash_cache_core_defines.svh
// Assertion macros used by the cache core RTL
`ifndef PORT_LABEL_HASH_CACHE_CORE_DEFINES_SVH
`define PORT_LABEL_HASH_CACHE_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PLHC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plhc assertion failed");

// next-cycle implication, checked while out of reset
`define PLHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plhc assertion failed");

`endif

### hdl/plhc_pkg.sv
package plhc_pkg;

    localparam int PROTO_W    = 8;
    localparam int PORT_W     = 16;
    localparam int LABEL_IO_W = 32;
    localparam int KEY_W      = PROTO_W + PORT_W;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_CMP
    } state_t;

endpackage

### hdl/plhc_meta.sv
module plhc_meta
    import plhc_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [$clog2(BUCKETS)-1:0]            rd_addr,
    output logic [$clog2(WAYS+1)-1:0]             rd_fill,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] rd_head,
    input  logic                                  wr_en,
    input  logic [$clog2(BUCKETS)-1:0]            wr_addr,
    input  logic [$clog2(WAYS+1)-1:0]             wr_fill,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] wr_head,
    input  logic                                  flush
);

    localparam int FW = $clog2(WAYS + 1);
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [FW+WB-1:0] mem [BUCKETS];
    logic [BUCKETS-1:0] valid_reg;
    logic [FW+WB-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_fill, wr_head};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a bucket never written since the last flush reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (flush)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_fill = rd_valid_reg ? rd_data_reg[FW+WB-1:WB] : '0;
    assign rd_head = rd_valid_reg ? rd_data_reg[WB-1:0] : '0;

endmodule

### hdl/plhc_store.sv
module plhc_store
    import plhc_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int WAYS       = 16,
    parameter int LABEL_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rd_en,
    input  logic [$clog2(BUCKETS)-1:0]            rd_addr,
    input  logic [KEY_W-1:0]                      key,
    input  logic [$clog2(WAYS+1)-1:0]             fill,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] head,
    output logic                                  hit,
    output logic [LABEL_BITS-1:0]                 hit_label,
    input  logic                                  wr_en,
    input  logic [$clog2(BUCKETS)-1:0]            wr_addr,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] wr_slot,
    input  logic [KEY_W+LABEL_BITS-1:0]           wr_entry
);

    localparam int FW = $clog2(WAYS + 1);
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW = KEY_W + LABEL_BITS;

    logic [WAYS*EW-1:0] mem [BUCKETS];
    logic [WAYS*EW-1:0] row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_slot*EW +: EW] <= wr_entry;
        end
        if (rd_en)
        begin
            row_reg <= mem[rd_addr];
        end
    end

    // keys are unique within a bucket, so at most one live slot matches
    always_comb
    begin
        logic [WB:0] off;
        logic [EW-1:0] ent;
        logic live;
        hit       = 1'b0;
        hit_label = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            ent = row_reg[j*EW +: EW];
            if ((WB+1)'(j) >= {1'b0, head})
            begin
                off = (WB+1)'(j) - {1'b0, head};
            end
            else
            begin
                off = (WB+1)'(j + WAYS) - {1'b0, head};
            end
            live = ((FW+WB+1)'(off) < (FW+WB+1)'(fill));
            if (live && (ent[EW-1:LABEL_BITS] == key))
            begin
                hit       = 1'b1;
                hit_label = hit_label | ent[LABEL_BITS-1:0];
            end
        end
    end

endmodule

### hdl/port_label_hash_cache_core.sv
// Channel   Dir  Beat fields (lowest bit first)
// s_axis    in   tuser: kind[1:0]; tdata: protocol, port_number, label_in
// m_axis    out  tuser: hit, evicted; tdata: label_out
// An item is handled in order: bucket read from the row and meta memories, then
// compare, write back and result. With BUCKETS not a power of two the bucket
// index is reduced first by a reciprocal multiply and then a multiply-subtract,
// each a step of its own in ST_MOD.
// Reset and flush clear all bucket valid bits at once; no clearing pass.
// s_axis_tready is low from the accept until the result is registered; after
// that it stays low only while the held result waits for m_axis_tready.
`include "port_label_hash_cache_core_defines.svh"

module port_label_hash_cache_core
    import plhc_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int WAYS       = 16,
    parameter int LABEL_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // protocol[7:0], port_number[23:8], label_in[55:24]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // label_out[31:0]
    output logic [1:0]  m_axis_tuser   // hit[0], evicted[1]
);

    localparam int FW = $clog2(WAYS + 1);
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BW = $clog2(BUCKETS);
    localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    // floor(port / BUCKETS) == (port * RECIP) >> 32 for every 16-bit port
    localparam logic [31:0] RECIP = 32'(((64'd1 << 32) / BUCKETS) + 1);

    state_t state_reg, state_next;
    logic [PORT_W-1:0]    rem_reg, rem_next;
    logic [PORT_W-1:0]    quo_reg, quo_next;
    logic [3:0]           step_reg, step_next;
    logic [1:0]           kind_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [LABEL_BITS-1:0] label_reg;
    logic                 out_valid_reg;
    logic                 out_hit_reg, out_evict_reg;
    logic [LABEL_IO_W-1:0] out_label_reg;

    logic                 accept;
    logic                 rd_en;
    logic [BW-1:0]        rd_addr;
    logic [FW-1:0]        fill;
    logic [WB-1:0]        head;
    logic                 hit;
    logic [LABEL_BITS-1:0] hit_label;
    logic                 meta_we, store_we, flush;
    logic [FW-1:0]        fill_next;
    logic [WB-1:0]        head_next, ins_slot;
    logic                 res_hit, res_evict;
    logic [LABEL_BITS-1:0] res_label;
    logic [PORT_W+31:0]   prod;
    logic [PORT_W-1:0]    rem_mod;
    logic [LABEL_BITS+LABEL_IO_W-1:0] out_ext;
    logic [LABEL_BITS+LABEL_IO_W-1:0] in_ext;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);

    // port modulo BUCKETS: quotient by reciprocal, then subtract quotient times BUCKETS
    assign prod    = (PORT_W+32)'(rem_reg) * (PORT_W+32)'(RECIP);
    assign rem_mod = rem_reg - quo_reg * PORT_W'(BUCKETS);

    assign in_ext = {{LABEL_BITS{1'b0}}, s_axis_tdata[55:24]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CMP)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (accept)
        begin
            kind_reg  <= s_axis_tuser;
            key_reg   <= s_axis_tdata[23:0];
            label_reg <= in_ext[LABEL_BITS-1:0];
        end
        if (state_reg == ST_CMP)
        begin
            out_hit_reg   <= res_hit;
            out_evict_reg <= res_evict;
            out_label_reg <= out_ext[LABEL_IO_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        rd_en      = 1'b0;
        rd_addr    = s_axis_tdata[8 +: BW];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next  = s_axis_tdata[23:8];
                    step_next = 4'd1;
                    if (BKT_POW2)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (step_reg != 4'd0)
                begin
                    quo_next  = prod[PORT_W+31:32];
                    step_next = 4'd0;
                end
                else
                begin
                    rem_next   = rem_mod;
                    rd_en      = 1'b1;
                    rd_addr    = rem_mod[BW-1:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // decide hit, insert slot, eviction and new ring state for the current bucket, or raise flush
    always_comb
    begin
        logic [WB:0] sum;
        res_hit   = 1'b0;
        res_evict = 1'b0;
        res_label = '0;
        meta_we   = 1'b0;
        store_we  = 1'b0;
        flush     = 1'b0;
        fill_next = fill;
        head_next = head;
        sum       = {1'b0, head} + (WB+1)'(fill);
        ins_slot  = (sum >= (WB+1)'(WAYS)) ? WB'(sum - (WB+1)'(WAYS)) : sum[WB-1:0];
        if (state_reg == ST_CMP)
        begin
            case (kind_reg) inside
                KIND_FLUSH:
                begin
                    flush = 1'b1;
                end
                KIND_LOOKUP, KIND_INSERT:
                begin
                    if (hit)
                    begin
                        res_hit   = 1'b1;
                        res_label = hit_label;
                    end
                    else if (kind_reg == KIND_INSERT)
                    begin
                        res_label = label_reg;
                        meta_we   = 1'b1;
                        store_we  = 1'b1;
                        if ((FW+1)'(fill) < (FW+1)'(WAYS))
                        begin
                            fill_next = fill + FW'(1);
                        end
                        else
                        begin
                            ins_slot  = head;
                            head_next = ((WB+1)'(head) + 1'b1 == (WB+1)'(WAYS)) ? '0 : head + WB'(1);
                            res_evict = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_hit = 1'b0;
                end
            endcase
        end
    end

    assign out_ext = {{LABEL_IO_W{1'b0}}, res_label};

    plhc_meta #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_meta (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_fill (fill),
        .rd_head (head),
        .wr_en   (meta_we),
        .wr_addr (rem_reg[BW-1:0]),
        .wr_fill (fill_next),
        .wr_head (head_next),
        .flush   (flush)
    );

    plhc_store #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .LABEL_BITS (LABEL_BITS)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .key       (key_reg),
        .fill      (fill),
        .head      (head),
        .hit       (hit),
        .hit_label (hit_label),
        .wr_en     (store_we),
        .wr_addr   (rem_reg[BW-1:0]),
        .wr_slot   (ins_slot),
        .wr_entry  ({key_reg, label_reg})
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_label_reg;
    assign m_axis_tuser  = {out_evict_reg, out_hit_reg};

    `PLHC_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)
    `PLHC_ASSERT_NEXT(a_result_after_cmp, state_reg == ST_CMP, m_axis_tvalid)
    `PLHC_ASSERT_NOW(a_hit_no_evict, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
    `PLHC_ASSERT_NOW(a_fill_bound, meta_we, (FW+1)'(fill_next) <= (FW+1)'(WAYS))

endmodule

### tb/port_label_hash_cache_core_test.sv
module port_label_hash_cache_core_test;
    import plhc_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [31:0] label;
        logic        evicted;
    } verdict_t;

    class label_scoreboard;
        logic [7:0]  slot_proto [256][16];
        logic [15:0] slot_port  [256][16];
        logic [31:0] slot_label [256][16];
        int          fill [256];
        int          head [256];
        verdict_t    pending [$];
        int          errors;

        function new();
            errors = 0;
            for (int b = 0; b < 256; b++)
            begin
                fill[b] = 0;
                head[b] = 0;
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [7:0] proto, logic [15:0] port,
                                   logic [31:0] label);
            verdict_t v;
            int bkt;
            int found;
            int s;
            v = '0;
            bkt = port[7:0];
            found = -1;
            if (kind == KIND_FLUSH)
            begin
                for (int b = 0; b < 256; b++)
                begin
                    fill[b] = 0;
                    head[b] = 0;
                end
            end
            else if (kind == KIND_LOOKUP || kind == KIND_INSERT)
            begin
                for (int i = 0; i < fill[bkt]; i++)
                begin
                    s = (head[bkt] + i) % 16;
                    if (found < 0 && slot_proto[bkt][s] == proto && slot_port[bkt][s] == port)
                        found = s;
                end
                if (found >= 0)
                begin
                    v.hit = 1'b1;
                    v.label = slot_label[bkt][found];
                end
                else if (kind == KIND_INSERT)
                begin
                    if (fill[bkt] < 16)
                    begin
                        s = (head[bkt] + fill[bkt]) % 16;
                        fill[bkt]++;
                    end
                    else
                    begin
                        s = head[bkt];
                        head[bkt] = (head[bkt] + 1) % 16;
                        v.evicted = 1'b1;
                    end
                    slot_proto[bkt][s] = proto;
                    slot_port[bkt][s] = port;
                    slot_label[bkt][s] = label;
                    v.label = label;
                end
            end
            pending.push_back(v);
        endfunction

        function void check_result(logic hit, logic [31:0] label, logic evicted);
            verdict_t v;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b label=%h evicted=%0b",
                         $time, hit, label, evicted);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (hit !== v.hit)
            begin
                $display("%0t: hit expected %0b actual %0b", $time, v.hit, hit);
                errors++;
            end
            if (label !== v.label)
            begin
                $display("%0t: label expected %h actual %h", $time, v.label, label);
                errors++;
            end
            if (evicted !== v.evicted)
            begin
                $display("%0t: evicted expected %0b actual %0b", $time, v.evicted, evicted);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    label_scoreboard board;
    int  cycles;
    bit  hold_off;

    port_label_hash_cache_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // send one beat; gap drawn per item, valid held across back-to-back beats
    task automatic send_beat(logic [1:0] kind, logic [7:0] proto, logic [15:0] port,
                             logic [31:0] label);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {label, port, proto};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(kind, proto, port, label);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: per-beat stall, plus a long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            board.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
        end
    end

    initial
    begin
        logic [1:0]  kind;
        logic [7:0]  proto;
        logic [15:0] port;
        int r;
        board = new();
        hold_off = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_LOOKUP;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: miss, insert, hit, duplicate insert, extremes, fill and evict, reserved kind, flush
        send_beat(KIND_LOOKUP, 8'h00, 16'h0000, 32'h0);
        send_beat(KIND_INSERT, 8'hff, 16'hffff, 32'hffffffff);
        send_beat(KIND_LOOKUP, 8'hff, 16'hffff, 32'h0);
        send_beat(KIND_INSERT, 8'hff, 16'hffff, 32'h12345678);
        send_beat(KIND_INSERT, 8'h00, 16'h0000, 32'h00000000);
        send_beat(KIND_LOOKUP, 8'h00, 16'h00ff, 32'h0);
        for (int i = 0; i < 17; i++)
            send_beat(KIND_INSERT, 8'(i), {8'(i), 8'h42}, 32'hA5A50000 + i);
        send_beat(KIND_LOOKUP, 8'h00, 16'h0042, 32'h0);
        send_beat(KIND_RSVD, 8'h06, 16'h0042, 32'hdeadbeef);
        send_beat(KIND_FLUSH, 8'h11, 16'h0050, 32'h0);
        send_beat(KIND_LOOKUP, 8'h01, 16'h0142, 32'h0);
        drain_results();

        // random: small key space so hits and evictions are common
        for (int n = 0; n < 1200; n++)
        begin
            if (n == 300)
                hold_off = 1'b1;
            if (n == 700)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = KIND_INSERT;
            else if (r < 95)
                kind = KIND_LOOKUP;
            else if (r < 98)
                kind = KIND_RSVD;
            else
                kind = KIND_FLUSH;
            if ($urandom_range(0, 9) < 8)
            begin
                proto = 8'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 8'hf0 : 8'h00);
                port = {8'($urandom_range(0, 3) * 85), 8'($urandom_range(0, 3))};
            end
            else
            begin
                proto = 8'($urandom);
                port = 16'($urandom);
            end
            send_beat(kind, proto, port, $urandom);
        end
        drain_results();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
